[hdl/zfn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package zfn_pkg;

  localparam int MAX_OBS   = 64;
  localparam int IDX_W     = $clog2(MAX_OBS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int X_W       = 32;
  localparam int EPS_W     = 17;
  localparam int SUM_W     = X_W + CNT_W - 1;
  localparam int SQ_W      = 2 * X_W + CNT_W - 2;
  localparam int NUM_W     = SQ_W + CNT_W - 1;
  localparam int DZ_W      = X_W + 1 + CNT_W;
  localparam int DEN_W     = DZ_W + 1;
  localparam int D_W       = X_W + CNT_W + 1;
  localparam int RAD_W     = 2 * X_W;
  localparam int ROOT_W    = X_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mean_start;
    logic mean_load;
    logic sqr_start;
    logic var_start;
    logic sqrt_start;
    logic den_load;
    logic diff_load;
    logic z_start;
    logic out_load;
    logic idx_inc;
    logic batch_clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqr_busy;
    logic sqrt_busy;
    logic one_obs;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[hdl/zfn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module zfn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/zfn_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module zfn_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [zfn_pkg::NUM_W-1:0] num,
  input  wire logic [zfn_pkg::DEN_W-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic      [zfn_pkg::NUM_W-1:0] quo
);

  // restoring divider, one quotient bit per cycle
  logic [zfn_pkg::DEN_W:0]       rem_r, rem_nxt;
  logic [zfn_pkg::NUM_W-1:0]     q_r, q_nxt;
  logic [zfn_pkg::DEN_W-1:0]     den_r;
  logic [zfn_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [zfn_pkg::DEN_W:0]       rem_sh;
  logic [zfn_pkg::DEN_W+1:0]     diff;
  logic                          ge;

  always_comb begin
    rem_sh  = {rem_r[zfn_pkg::DEN_W-1:0], q_r[zfn_pkg::NUM_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, den_r};
    ge      = ~diff[zfn_pkg::DEN_W+1];
    rem_nxt = ge ? diff[zfn_pkg::DEN_W:0] : rem_sh;
    q_nxt   = {q_r[zfn_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= zfn_pkg::DIV_CNT_W'(zfn_pkg::NUM_W);
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == zfn_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

[hdl/zfn_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module zfn_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire zfn_pkg::cmd_t               cmd,
  output zfn_pkg::sts_t                    sts,
  input  wire logic signed [zfn_pkg::X_W-1:0]   in_sample,
  input  wire logic                        cfg_we,
  input  wire logic [zfn_pkg::EPS_W-1:0]   cfg_wdata,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic signed [zfn_pkg::X_W-1:0]   out_normalized,
  output logic [zfn_pkg::IDX_W-1:0]        out_obs_index,
  output logic signed [zfn_pkg::X_W-1:0]   out_feature_mean,
  output logic [zfn_pkg::X_W-1:0]          out_feature_std,
  output logic                             out_final_res
);

  localparam int CW = zfn_pkg::CNT_W;
  localparam int XW = zfn_pkg::X_W;
  localparam int NW = zfn_pkg::NUM_W;
  localparam int MCNT_W = $clog2(zfn_pkg::SUM_W + 1);
  localparam int RCNT_W = $clog2(zfn_pkg::ROOT_W + 1);

  // batch state
  logic [zfn_pkg::EPS_W-1:0]        eps_r;
  logic [CW-1:0]                    cnt_r;
  logic signed [zfn_pkg::SUM_W-1:0] sum_r;
  logic [2*XW-1:0]                  sq_pipe_r;
  logic                             sq_vld_r;
  logic [zfn_pkg::SQ_W-1:0]         sq_acc_r;
  logic                             store_en;
  logic [XW-1:0]                    in_mag;
  logic [zfn_pkg::SUM_W-1:0]        smag;

  // statistics
  logic [XW-1:0]                    mean_r;
  logic [NW-1:0]                    ma_r, s2_r, nq_r;
  logic [zfn_pkg::SUM_W-1:0]        mb_r;
  logic [MCNT_W-1:0]                mcnt_r;
  logic                             sqr_busy_r;
  logic [zfn_pkg::RAD_W-1:0]        rad_r;
  logic [zfn_pkg::ROOT_W-1:0]       root_r, root_nxt;
  logic [zfn_pkg::ROOT_W+1:0]       rrem_r;
  logic [zfn_pkg::ROOT_W+2:0]       rrem_sh, rtrial, rrem_diff;
  logic                             rge;
  logic [RCNT_W-1:0]                rcnt_r;
  logic                             sqrt_busy_r;
  logic [XW-1:0]                    sd_r;
  logic [zfn_pkg::DZ_W-1:0]         dz_r;
  logic [zfn_pkg::EPS_W-1:0]        eps_eff;

  // per sample
  logic [zfn_pkg::IDX_W-1:0]        idx_r;
  logic [XW-1:0]                    ram_rdata;
  logic signed [zfn_pkg::D_W-1:0]   d_r, d_nxt;
  logic [zfn_pkg::D_W-1:0]          dmag;
  logic                             out_valid_r;
  logic [XW-1:0]                    z_val;

  // divider
  logic                             div_start, div_busy, div_done;
  logic [NW-1:0]                    div_num, div_quo;
  logic [zfn_pkg::DEN_W-1:0]        div_den;

  assign store_en = cmd.accept && (cnt_r < CW'(zfn_pkg::MAX_OBS));
  assign in_mag   = in_sample[XW-1] ? (~in_sample + 1'b1) : in_sample;
  assign smag     = sum_r[zfn_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign eps_eff  = (eps_r == '0) ? zfn_pkg::EPS_W'(1) : eps_r;
  assign dmag     = d_r[zfn_pkg::D_W-1] ? (~d_r + 1'b1) : d_r;

  zfn_ram #(.WIDTH(XW), .DEPTH(zfn_pkg::MAX_OBS)) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (cnt_r[zfn_pkg::IDX_W-1:0]),
    .wdata (in_sample),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // one divider shared by mean, variance and every z-score
  always_comb begin
    div_start = cmd.mean_start | cmd.var_start | cmd.z_start;
    div_num   = '0;
    div_den   = '0;
    if (cmd.mean_start) begin
      div_num = NW'({smag, 1'b0}) + NW'(cnt_r);
      div_den = zfn_pkg::DEN_W'({cnt_r, 1'b0});
    end else if (cmd.var_start) begin
      div_num = nq_r - s2_r;
      div_den = zfn_pkg::DEN_W'(cnt_r * (cnt_r - 1'b1));
    end else if (cmd.z_start) begin
      div_num = NW'({dmag, 17'b0}) + NW'(dz_r);
      div_den = {dz_r, 1'b0};
    end
  end

  zfn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // square root step: two radicand bits per cycle
  always_comb begin
    rrem_sh   = {rrem_r[zfn_pkg::ROOT_W:0], rad_r[zfn_pkg::RAD_W-1 -: 2]};
    rtrial    = {1'b0, root_r, 2'b01};
    rge       = rrem_sh >= rtrial;
    rrem_diff = rge ? (rrem_sh - rtrial) : rrem_sh;
    root_nxt  = {root_r[zfn_pkg::ROOT_W-2:0], rge};
  end

  always_comb begin
    d_nxt = zfn_pkg::D_W'($signed({1'b0, cnt_r}) * $signed(ram_rdata))
          - zfn_pkg::D_W'(sum_r);
    if (d_r[zfn_pkg::D_W-1]) begin
      z_val = (div_quo > NW'(33'h080000000)) ? 32'h80000000 : (~div_quo[XW-1:0] + 1'b1);
    end else begin
      z_val = (div_quo > NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : div_quo[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r       <= zfn_pkg::EPS_W'(1);
      cnt_r       <= '0;
      sum_r       <= '0;
      sq_acc_r    <= '0;
      sq_vld_r    <= 1'b0;
      sqr_busy_r  <= 1'b0;
      sqrt_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end

      // load: store and sum; the square is accumulated in the cycle after
      sq_vld_r <= store_en;
      if (store_en) begin
        cnt_r     <= cnt_r + 1'b1;
        sum_r     <= sum_r + zfn_pkg::SUM_W'(in_sample);
        sq_pipe_r <= in_mag * in_mag;
      end
      if (sq_vld_r) begin
        sq_acc_r <= sq_acc_r + zfn_pkg::SQ_W'(sq_pipe_r);
      end

      if (cmd.mean_load) begin
        mean_r <= sum_r[zfn_pkg::SUM_W-1] ? (~div_quo[XW-1:0] + 1'b1) : div_quo[XW-1:0];
        sd_r   <= '0;
      end

      // shift-add square of the sum
      if (cmd.sqr_start) begin
        ma_r       <= NW'(smag);
        mb_r       <= smag;
        s2_r       <= '0;
        nq_r       <= NW'(cnt_r * sq_acc_r);
        mcnt_r     <= MCNT_W'(zfn_pkg::SUM_W);
        sqr_busy_r <= 1'b1;
      end else if (sqr_busy_r) begin
        if (mb_r[0]) begin
          s2_r <= s2_r + ma_r;
        end
        ma_r   <= {ma_r[NW-2:0], 1'b0};
        mb_r   <= {1'b0, mb_r[zfn_pkg::SUM_W-1:1]};
        mcnt_r <= mcnt_r - 1'b1;
        if (mcnt_r == MCNT_W'(1)) begin
          sqr_busy_r <= 1'b0;
        end
      end

      // variance quotient saturates to the radicand width
      if (cmd.sqrt_start) begin
        rad_r       <= (div_quo[NW-1:zfn_pkg::RAD_W] != '0) ? '1
                       : div_quo[zfn_pkg::RAD_W-1:0];
        root_r      <= '0;
        rrem_r      <= '0;
        rcnt_r      <= RCNT_W'(zfn_pkg::ROOT_W);
        sqrt_busy_r <= 1'b1;
      end else if (sqrt_busy_r) begin
        rad_r  <= {rad_r[zfn_pkg::RAD_W-3:0], 2'b00};
        root_r <= root_nxt;
        rrem_r <= rrem_diff[zfn_pkg::ROOT_W+1:0];
        rcnt_r <= rcnt_r - 1'b1;
        if (rcnt_r == RCNT_W'(1)) begin
          sqrt_busy_r <= 1'b0;
          sd_r        <= root_nxt;
        end
      end

      if (cmd.den_load) begin
        dz_r  <= zfn_pkg::DZ_W'(cnt_r * ({1'b0, sd_r} + (XW + 1)'(eps_eff)));
        idx_r <= '0;
      end
      if (cmd.diff_load) begin
        d_r <= d_nxt;
      end
      if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end

      if (cmd.out_load) begin
        out_valid_r      <= 1'b1;
        out_normalized   <= z_val;
        out_obs_index    <= idx_r;
        out_feature_mean <= mean_r;
        out_feature_std  <= sd_r;
        out_final_res    <= sts.idx_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.batch_clear) begin
        cnt_r    <= '0;
        sum_r    <= '0;
        sq_acc_r <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.div_done  = div_done;
  assign sts.sqr_busy  = sqr_busy_r;
  assign sts.sqrt_busy = sqrt_busy_r;
  assign sts.one_obs   = (cnt_r == CW'(1));
  assign sts.idx_last  = ({1'b0, idx_r} == (cnt_r - 1'b1));
  assign sts.out_free  = !out_valid_r || out_ready;

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.batch_clear |=> (cnt_r == '0 && sum_r == '0))
    else $error("batch not cleared");

endmodule
`default_nettype wire

[hdl/zfn_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module zfn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  output zfn_pkg::cmd_t      cmd,
  input  wire zfn_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_LOAD, S_MSTART, S_MWAIT, S_SQSTART, S_SQRUN, S_VSTART, S_VWAIT,
    S_RTRUN, S_DEN, S_RD, S_DIFF, S_ZSTART, S_ZWAIT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.mean_start = 1'b1;
        state_nxt      = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.div_done) begin
          cmd.mean_load = 1'b1;
          state_nxt     = sts.one_obs ? S_DEN : S_SQSTART;
        end
      end
      S_SQSTART: begin
        cmd.sqr_start = 1'b1;
        state_nxt     = S_SQRUN;
      end
      S_SQRUN: begin
        if (!sts.sqr_busy) begin
          state_nxt = S_VSTART;
        end
      end
      S_VSTART: begin
        cmd.var_start = 1'b1;
        state_nxt     = S_VWAIT;
      end
      S_VWAIT: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_RTRUN;
        end
      end
      S_RTRUN: begin
        if (!sts.sqrt_busy) begin
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        cmd.den_load = 1'b1;
        state_nxt    = S_RD;
      end
      S_RD: begin
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_load = 1'b1;
        state_nxt     = S_ZSTART;
      end
      S_ZSTART: begin
        cmd.z_start = 1'b1;
        state_nxt   = S_ZWAIT;
      end
      S_ZWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.idx_last) begin
            cmd.batch_clear = 1'b1;
            state_nxt       = S_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_LOAD);

  a_wait_sqr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VSTART) |-> !sts.sqr_busy)
    else $error("variance started before square done");

  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mean_start, cmd.var_start, cmd.z_start}))
    else $error("two divider starts at once");

  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_last) |=> !in_ready)
    else $error("input taken after batch end");

endmodule
`default_nettype wire

[hdl/zscore_feature_normalizer_core.sv]
`timescale 1ns / 1ps
// load: one item per cycle, up to 64 samples, the last item ends the batch
// after the last item: mean divide, square of sum, variance divide,
// square root, denominator
// (square of sum, variance divide and square root skipped for one sample)
// then results one by one from the 75-step shared restoring divider
// synchronous active-low reset: empty batch, epsilon 1, no result pending
`default_nettype none
module zscore_feature_normalizer_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // sample input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [zfn_pkg::X_W-1:0] in_sample,
  input  wire logic                           in_last,
  // epsilon register
  input  wire logic                           cfg_we,
  input  wire logic [zfn_pkg::EPS_W-1:0]      cfg_wdata,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [zfn_pkg::X_W-1:0]      out_normalized,
  output logic [zfn_pkg::IDX_W-1:0]           out_obs_index,
  output logic signed [zfn_pkg::X_W-1:0]      out_feature_mean,
  output logic [zfn_pkg::X_W-1:0]             out_feature_std,
  output logic                                out_final_res
);

  // sequencer drives the datapath by command struct only
  zfn_pkg::cmd_t cmd;
  zfn_pkg::sts_t sts;

  zfn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: sample store, sums, shared divider, sqrt, output register
  zfn_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_normalized   (out_normalized),
    .out_obs_index    (out_obs_index),
    .out_feature_mean (out_feature_mean),
    .out_feature_std  (out_feature_std),
    .out_final_res    (out_final_res)
  );

endmodule
`default_nettype wire
